// ===== rtl/trcv_pkg.sv =====
// Shared types, constants and helpers for the tile row checksum validator.
package trcv_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CFG_W  = 11;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int FACT_W = 17;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH    = 2'd0,
    REG_GRID_HEIGHT   = 2'd1,
    REG_EXPECTED_ROWS = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] grid_width;
    logic [CFG_W-1:0] grid_height;
    logic [CFG_W-1:0] expected_rows;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        mask_id;
    logic [15:0]        terrain_id;
    logic signed [15:0] tile_height;
    logic [31:0]        expected_sum;
  } tile_t;

  typedef struct packed {
    logic [9:0]  row_index;
    logic [31:0] row_sum;
    logic        row_match;
    logic        integrity_ok;
    logic        grid_done;
  } row_result_t;

  // One classified tile as handed from front to back
  typedef struct packed {
    logic [15:0]        mask_id;
    logic signed [15:0] tile_height;
    logic [31:0]        expected_sum;
    logic [FACT_W-1:0]  fact_left;
    logic [FACT_W-1:0]  fact_right;
    logic [ROW_W-1:0]   row_index;
    logic               last_col;
    logic               last_row;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Map a size register onto 1..max
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] max);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > max) begin
      r = max;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/trcv_front.sv =====
// Front end: accepts tiles, tracks column and row, classifies each tile.
module trcv_front (
  input  logic              clk,
  input  logic              rst,
  input  trcv_pkg::cfg_t    cfg,
  input  logic              tile_valid,
  output logic              tile_ready,
  input  trcv_pkg::tile_t   tile,
  input  trcv_pkg::q_stat_t q_stat,
  output logic              q_push,
  output trcv_pkg::q_entry_t q_data
);
  import trcv_pkg::*;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [CFG_W-1:0] width_eff;
  logic [CFG_W-1:0] rows_eff;
  logic             last_col;
  logic             last_row;

  // Effective grid size
  assign width_eff = clamp_size(cfg.grid_width, CFG_W'(MAX_WIDTH));
  assign rows_eff  = clamp_size(cfg.grid_height, CFG_W'(MAX_HEIGHT));

  // Classify the current tile position
  assign last_col = (CFG_W'(col) + CFG_W'(1)) >= width_eff;
  assign last_row = (CFG_W'(row) + CFG_W'(1)) >= rows_eff;

  assign tile_ready = !q_stat.full;
  assign q_push     = tile_valid && tile_ready;

  // Build the queue entry, with the multiplier factors already summed
  always_comb begin
    q_data.mask_id      = tile.mask_id;
    q_data.tile_height  = tile.tile_height;
    q_data.expected_sum = tile.expected_sum;
    q_data.fact_left    = {1'b0, tile.terrain_id} + FACT_W'(row) + FACT_W'(1);
    q_data.fact_right   = {1'b0, tile.terrain_id} + FACT_W'(col) + FACT_W'(1);
    q_data.row_index    = row;
    q_data.last_col     = last_col;
    q_data.last_row     = last_row;
  end

  // Advance the raster position on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (q_push) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/trcv_queue.sv =====
// Short queue of classified tiles between front and back.
module trcv_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  trcv_pkg::q_entry_t push_data,
  input  logic               pop,
  output trcv_pkg::q_entry_t pop_data,
  output trcv_pkg::q_stat_t  stat
);
  import trcv_pkg::*;

  q_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = slots[rd_ptr];

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/trcv_back.sv =====
// Back end: multiplies, accumulates row sums and reports finished rows.
module trcv_back (
  input  logic                  clk,
  input  logic                  rst,
  input  trcv_pkg::cfg_t        cfg,
  input  trcv_pkg::q_entry_t    q_data,
  input  trcv_pkg::q_stat_t     q_stat,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output trcv_pkg::row_result_t res
);
  import trcv_pkg::*;

  // Multiply stage
  logic                mul_valid;
  logic [31:0]         mul_left;
  logic [31:0]         mul_right;
  logic [31:0]         mul_expected;
  logic [ROW_W-1:0]    mul_row;
  logic                mul_last_col;
  logic                mul_last_row;

  // Row state
  logic [31:0]         row_acc;
  logic                integrity;

  logic [32:0]         prod_left;
  logic signed [17:0]  height_adj;
  logic signed [17:0]  fact_right_s;
  logic signed [35:0]  prod_right;
  logic                mul_take;
  logic                mul_free;
  logic [31:0]         sum;
  logic                cmp_off;
  logic                match;
  logic                row_ok;
  logic                integrity_next;

  // Products of the head entry
  assign prod_left    = {17'd0, q_data.mask_id} * {16'd0, q_data.fact_left};
  assign height_adj   = $signed({{2{q_data.tile_height[15]}}, q_data.tile_height})
                        + 18'sd2;
  assign fact_right_s = $signed({1'b0, q_data.fact_right});
  assign prod_right   = height_adj * fact_right_s;

  // A row end needs the output register free
  assign mul_take = mul_valid && (!mul_last_col || !res_valid || res_ready);
  assign mul_free = !mul_valid || mul_take;
  assign q_pop    = mul_free && !q_stat.empty;

  // Row sum and checks
  assign sum            = row_acc + mul_left + mul_right;
  assign cmp_off        = (cfg.expected_rows == '0);
  assign match          = cmp_off || (sum == mul_expected);
  assign row_ok         = cmp_off || (match && (cfg.expected_rows == cfg.grid_height));
  assign integrity_next = integrity && row_ok;

  // Load the multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (q_pop) begin
      mul_valid <= 1'b1;
    end else if (mul_take) begin
      mul_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mul_left     <= prod_left[31:0];
      mul_right    <= prod_right[31:0];
      mul_expected <= q_data.expected_sum;
      mul_row      <= q_data.row_index;
      mul_last_col <= q_data.last_col;
      mul_last_row <= q_data.last_row;
    end
  end

  // Accumulate, close rows and passes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc   <= '0;
      integrity <= 1'b1;
    end else if (mul_take) begin
      if (mul_last_col) begin
        row_acc   <= '0;
        integrity <= mul_last_row ? 1'b1 : integrity_next;
      end else begin
        row_acc <= sum;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (mul_take && mul_last_col) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_take && mul_last_col) begin
      res.row_index    <= 10'(mul_row);
      res.row_sum      <= sum;
      res.row_match    <= match;
      res.integrity_ok <= integrity_next;
      res.grid_done    <= mul_last_row;
    end
  end

endmodule

// ===== rtl/tile_row_checksum_validator_top.sv =====
// Top level of the tile row checksum validator: registers, front, queue, back.
//
//   channel  direction  handshake                payload
//   tile     in         tile_valid / tile_ready  tile (tile_t)
//   res      out        res_valid / res_ready    res (row_result_t)
//   apb      in         psel/penable/pwrite      paddr, pwdata, prdata
//
// One tile per cycle is taken while the queue has room; the multiply stage
// and the row accumulator each handle one tile a cycle. A row result is
// registered from the multiply stage. Reset clears the raster position, the
// row sum and the queue and sets the integrity flag and registers to their
// defaults. A stalled result holds the back end only on a row end; the
// four-entry queue then takes up to four more tiles before tile_ready drops.
module tile_row_checksum_validator_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tile_valid,
  output logic                  tile_ready,
  input  trcv_pkg::tile_t       tile,
  output logic                  res_valid,
  input  logic                  res_ready,
  output trcv_pkg::row_result_t res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import trcv_pkg::*;

  cfg_t     cfg;
  reg_idx_e reg_idx;
  logic     reg_wr;
  logic     q_push;
  logic     q_pop;
  q_entry_t q_in;
  q_entry_t q_out;
  q_stat_t  q_stat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width    <= CFG_W'(1);
      cfg.grid_height   <= CFG_W'(1);
      cfg.expected_rows <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_GRID_WIDTH:    cfg.grid_width    <= pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT:   cfg.grid_height   <= pwdata[CFG_W-1:0];
        REG_EXPECTED_ROWS: cfg.expected_rows <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_GRID_WIDTH:    prdata = 32'(cfg.grid_width);
      REG_GRID_HEIGHT:   prdata = 32'(cfg.grid_height);
      REG_EXPECTED_ROWS: prdata = 32'(cfg.expected_rows);
      default:           prdata = '0;
    endcase
  end

  trcv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tile_valid (tile_valid),
    .tile_ready (tile_ready),
    .tile       (tile),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  trcv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  trcv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_data    (q_out),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Queue cannot be full and empty at once
  a_queue_sane: assert property (@(posedge clk) !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty");

  // Reset leaves no result and an empty queue
  a_reset_clears: assert property (@(posedge clk) rst |=> (!res_valid && q_stat.empty))
    else $error("state left after reset");

  // An accepted tile lands in the queue
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (tile_valid && tile_ready) |=> !q_stat.empty)
    else $error("accepted tile missing from queue");

  // A failed comparison clears integrity
  a_mismatch_integrity: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.row_match) |-> !res.integrity_ok)
    else $error("integrity set on mismatching row");

endmodule

// ===== test/trcv_row_checker.sv =====
// Checksum term helper and the scoreboard checker for the tile row checksum validator.
`timescale 1ns / 100ps

package trcv_tb_pkg;

  // Contribution of one tile to its row sum, all terms wrapping at 32 bits
  function automatic logic [31:0] tile_term(input logic [15:0]        mask,
                                            input logic [15:0]        terrain,
                                            input logic signed [15:0] hgt,
                                            input logic [31:0]        col,
                                            input logic [31:0]        row);
    logic [31:0] left;
    logic [31:0] right;
    left  = {16'd0, mask} * ({16'd0, terrain} + row + 32'd1);
    right = ({{16{hgt[15]}}, hgt} + 32'd2) * (col + 32'd1 + {16'd0, terrain});
    return left + right;
  endfunction

endpackage

module trcv_row_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tile_valid,
  input  logic                  tile_ready,
  input  trcv_pkg::tile_t       tile,
  input  logic                  res_valid,
  input  logic                  res_ready,
  input  trcv_pkg::row_result_t res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic [31:0]           prdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    rows_pending,
  output logic [31:0]           open_row_sum,
  output logic [31:0]           open_col,
  output logic [31:0]           open_row
);
  import trcv_pkg::*;
  import trcv_tb_pkg::*;

  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  logic [CFG_W-1:0] cfg_expected;
  logic [31:0]      col_pos;
  logic [31:0]      row_pos;
  logic [31:0]      row_acc;
  logic             run_ok;
  row_result_t      pending_rows[$];

  initial fail_count = 0;

  assign open_row_sum = row_acc;
  assign open_col     = col_pos;
  assign open_row     = row_pos;

  // Map a size register onto 1..limit
  function automatic logic [31:0] fit_size(input logic [CFG_W-1:0] v, input int unsigned limit);
    if (v == '0) begin
      return 32'd1;
    end else if (v > limit) begin
      return limit;
    end
    return {21'd0, v};
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Fold one tile beat into the row sum; queue a row result at the row end
  task automatic fold_tile(input tile_t t);
    logic [31:0] width_now;
    logic [31:0] rows_now;
    logic        row_ok;
    row_result_t r;
    width_now = fit_size(cfg_width, MAX_WIDTH);
    rows_now  = fit_size(cfg_height, MAX_HEIGHT);
    row_acc   = row_acc + tile_term(t.mask_id, t.terrain_id, t.tile_height, col_pos, row_pos);
    if (col_pos + 32'd1 < width_now) begin
      col_pos = col_pos + 32'd1;
    end else begin
      r.row_index = row_pos[9:0];
      r.row_sum   = row_acc;
      if (cfg_expected == '0) begin
        r.row_match = 1'b1;
        row_ok      = 1'b1;
      end else begin
        r.row_match = (row_acc == t.expected_sum);
        row_ok      = r.row_match && (cfg_expected == cfg_height);
      end
      run_ok         = run_ok && row_ok;
      r.integrity_ok = run_ok;
      r.grid_done    = (row_pos + 32'd1 >= rows_now);
      pending_rows   = {pending_rows, r};
      col_pos = '0;
      row_acc = '0;
      if (r.grid_done) begin
        row_pos = '0;
        run_ok  = 1'b1;
      end else begin
        row_pos = row_pos + 32'd1;
      end
    end
  endtask

  task automatic check_row(input row_result_t got);
    row_result_t want;
    if (pending_rows.size() == 0) begin
      fail_count++;
      $display("%0t: row result with none expected: expected nothing, got %h", $time, got);
    end else begin
      want = pending_rows.pop_front();
      report_field("row_index", 32'(want.row_index), 32'(got.row_index));
      report_field("row_sum", want.row_sum, got.row_sum);
      report_field("row_match", 32'(want.row_match), 32'(got.row_match));
      report_field("integrity_ok", 32'(want.integrity_ok), 32'(got.integrity_ok));
      report_field("grid_done", 32'(want.grid_done), 32'(got.grid_done));
    end
  endtask

  // Track register traffic and both channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      cfg_width    = CFG_W'(1);
      cfg_height   = CFG_W'(1);
      cfg_expected = '0;
      col_pos      = '0;
      row_pos      = '0;
      row_acc      = '0;
      run_ok       = 1'b1;
      pending_rows.delete();
    end else begin
      if (psel && penable && pready && pwrite) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_GRID_WIDTH:    cfg_width    = pwdata[CFG_W-1:0];
          REG_GRID_HEIGHT:   cfg_height   = pwdata[CFG_W-1:0];
          REG_EXPECTED_ROWS: cfg_expected = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
      if (psel && penable && pready && !pwrite) begin
        case (reg_idx_e'(paddr[3:2]))
          REG_GRID_WIDTH:    report_field("grid_width readback", 32'(cfg_width), prdata);
          REG_GRID_HEIGHT:   report_field("grid_height readback", 32'(cfg_height), prdata);
          REG_EXPECTED_ROWS: report_field("expected_rows readback", 32'(cfg_expected), prdata);
          default: ;
        endcase
      end
      if (tile_valid && tile_ready) begin
        fold_tile(tile);
      end
      if (res_valid && res_ready) begin
        check_row(res);
      end
    end
    // Publish how many row results are still owed
    rows_pending = pending_rows.size();
  end

endmodule

// ===== test/tb_tile_row_checksum_validator_top.sv =====
// Stimulus, receiver pacing and verdict for the tile row checksum validator.
`timescale 1ns / 100ps

module tb_tile_row_checksum_validator_top;
  import trcv_pkg::*;
  import trcv_tb_pkg::*;

  localparam int LATENCY_PAUSE   = 8;
  localparam int QUIET_LIMIT     = 5000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_TILES    = 150;

  // How the expected sum of a tile is formed
  localparam int SUM_RIGHT  = 0;
  localparam int SUM_FLIP   = 1;
  localparam int SUM_RANDOM = 2;
  localparam int SUM_FORCED = 3;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        tile_valid = 1'b0;
  logic        tile_ready;
  tile_t       tile       = '0;
  logic        res_valid;
  logic        res_ready  = 1'b0;
  row_result_t res;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [3:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          rows_pending;
  logic [31:0] open_row_sum;
  logic [31:0] open_col;
  logic [31:0] open_row;
  int          hold_requests = 0;
  int          burst_left    = 0;
  int          quiet_cycles  = 0;

  tile_row_checksum_validator_top u_top (
    .clk        (clk),
    .rst        (rst),
    .tile_valid (tile_valid),
    .tile_ready (tile_ready),
    .tile       (tile),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  trcv_row_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .tile_valid   (tile_valid),
    .tile_ready   (tile_ready),
    .tile         (tile),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .rows_pending (rows_pending),
    .open_row_sum (open_row_sum),
    .open_col     (open_col),
    .open_row     (open_row)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stop the run when nothing has been accepted for too long
  always @(posedge clk) begin
    if ((tile_valid && tile_ready) || (res_valid && res_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_tile_row_checksum_validator_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: switch between free flow, a periodic stall and random stalls;
  // a hold request forces a long stretch with ready low
  initial begin : receiver
    int style;
    int span;
    int hold_left;
    int seen;
    int tick;
    style     = 0;
    span      = 0;
    hold_left = 0;
    seen      = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (seen != hold_requests) begin
        seen      = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (span == 0) begin
        style = $urandom_range(0, 2);
        span  = $urandom_range(50, 400);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        res_ready = 1'b0;
      end else begin
        case (style)
          0:       res_ready = 1'b1;
          1:       res_ready = (tick % 8) >= 3;
          default: res_ready = $urandom_range(0, 1);
        endcase
      end
    end
  end

  task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [31:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Write a register with noise in the unused upper bits
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    logic [31:0] word;
    word          = $urandom();
    word[CFG_W-1:0] = value;
    apb_access(idx, 1'b1, word);
  endtask

  // Hold the sender until every row result has come, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    while (rows_pending != 0) @(negedge clk);
    repeat (LATENCY_PAUSE) @(negedge clk);
  endtask

  task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                          input logic [CFG_W-1:0] e);
    wait_idle();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_EXPECTED_ROWS, e);
    apb_access(REG_GRID_WIDTH, 1'b0, '0);
    apb_access(REG_GRID_HEIGHT, 1'b0, '0);
    apb_access(REG_EXPECTED_ROWS, 1'b0, '0);
  endtask

  task automatic drop_valid(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      tile_valid = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Present one tile and hold it until the beat; the expected sum is built
  // from the running row sum so that the row end may match
  task automatic send_tile(input logic [15:0] m, input logic [15:0] tr,
                           input logic signed [15:0] h, input int sum_mode,
                           input logic [31:0] forced);
    tile_t t;
    @(negedge clk);
    t.mask_id      = m;
    t.terrain_id   = tr;
    t.tile_height  = h;
    t.expected_sum = open_row_sum + tile_term(m, tr, h, open_col, open_row);
    case (sum_mode)
      SUM_FLIP:   t.expected_sum = t.expected_sum ^ (32'd1 << $urandom_range(0, 31));
      SUM_RANDOM: t.expected_sum = $urandom();
      SUM_FORCED: t.expected_sum = forced;
      default: ;
    endcase
    tile       = t;
    tile_valid = 1'b1;
    @(posedge clk);
    while (!tile_ready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hfffe;
      default: return 16'($urandom());
    endcase
  endfunction

  // Random tile in bursts, with an occasional wrong expected sum
  task automatic send_random(input bit paced);
    int pick;
    if (paced && burst_left == 0) begin
      drop_valid($urandom_range(1, 6));
      burst_left = $urandom_range(1, 30);
    end
    if (burst_left > 0) burst_left--;
    pick = $urandom_range(0, 9);
    send_tile(pick_id(), pick_id(), pick_height(),
              (pick == 0) ? SUM_FLIP : (pick == 1) ? SUM_RANDOM : SUM_RIGHT, '0);
  endtask

  initial begin : stimulus
    int w;
    int h;
    int e;
    int n;
    int sent;
    int phase;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset sizes, comparison off: field extremes and a zero height factor
    send_tile(16'h0000, 16'h0000, 16'sh0000, SUM_FORCED, 32'h0000_0000);
    send_tile(16'hffff, 16'hffff, 16'sh7fff, SUM_FORCED, 32'hffff_ffff);
    send_tile(16'hffff, 16'h0000, 16'sh8000, SUM_RIGHT, '0);
    send_tile(16'h0000, 16'hffff, -16'sd2, SUM_FLIP, '0);
    send_tile(16'h0001, 16'h0001, -16'sd1, SUM_RANDOM, '0);
    drop_valid(1);

    // Unmapped register is ignored; then a clean pass and a spoilt pass
    wait_idle();
    write_reg(REG_UNMAPPED, 11'h005);
    set_grid(11'd3, 11'd2, 11'd2);
    repeat (6) send_tile(pick_id(), pick_id(), pick_height(), SUM_RIGHT, '0);
    send_tile(16'h1234, 16'h00ff, 16'sh0100, SUM_RIGHT, '0);
    send_tile(16'hffff, 16'hffff, 16'sh8000, SUM_RIGHT, '0);
    send_tile(16'h0000, 16'h0000, 16'sh7fff, SUM_FLIP, '0);
    repeat (3) send_tile(pick_id(), pick_id(), pick_height(), SUM_RIGHT, '0);
    drop_valid(1);

    // Zero width acts as one; count differs from height
    set_grid(11'd0, 11'd3, 11'd1);
    repeat (3) send_tile(pick_id(), pick_id(), pick_height(), SUM_RIGHT, '0);
    drop_valid(1);

    // Shrink width, then height, while a row and a pass are open
    set_grid(11'd4, 11'd3, 11'd0);
    repeat (3) send_tile(pick_id(), pick_id(), pick_height(), SUM_RIGHT, '0);
    drop_valid(1);
    wait_idle();
    write_reg(REG_GRID_WIDTH, 11'd2);
    send_tile(pick_id(), pick_id(), pick_height(), SUM_RIGHT, '0);
    drop_valid(1);
    wait_idle();
    write_reg(REG_GRID_HEIGHT, 11'd1);
    repeat (2) send_tile(pick_id(), pick_id(), pick_height(), SUM_RIGHT, '0);
    drop_valid(1);

    // Oversized height clamps and the pass reaches the top row
    set_grid(11'd1, 11'd2047, 11'd2047);
    repeat (1024) send_random(1'b1);
    drop_valid(1);

    // Random phases, mostly whole grids, some cut short mid-row
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_TILES) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) w = $urandom_range(7, 40);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      case ($urandom_range(0, 3))
        0:       e = 0;
        3:       e = $urandom_range(0, 2047);
        default: e = h;
      endcase
      if (phase == 0) begin
        w = 1;
        h = 3;
      end
      set_grid(w[CFG_W-1:0], h[CFG_W-1:0], e[CFG_W-1:0]);
      if (phase == 0) begin
        hold_requests++;
        n = 80;
      end else if ($urandom_range(0, 3) != 0) begin
        n = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * $urandom_range(1, 3);
      end else begin
        n = $urandom_range(1, 40);
      end
      repeat (n) send_random(1'b1);
      drop_valid(1);
      sent += n;
      phase++;
    end

    // Drain and give the verdict
    wait_idle();
    if (fail_count == 0) begin
      $display("tb_tile_row_checksum_validator_top: PASS");
    end else begin
      $display("tb_tile_row_checksum_validator_top: FAIL");
    end
    $finish;
  end

endmodule
